[sv/pwd_pkg.sv]
// Package for the peer-wire message deframer.
// Holds the phase encoding, event codes, sizing constants, the result struct
// and the handshake protocol-string lookup. No dependencies.
package pwd_pkg;

   // Sizing of the handshake and of accepted messages
   localparam int unsigned HANDSHAKE_LEN  = 68;
   localparam logic [6:0]  HS_LAST        = 7'(HANDSHAKE_LEN - 1);
   localparam logic [6:0]  HS_CHECK_LAST  = 7'd19;
   localparam logic [7:0]  HS_PSTRLEN     = 8'd19;
   localparam logic [31:0] MAX_MESSAGE_LEN = 32'd131072;
   localparam logic [1:0]  LEN_LAST_BYTE  = 2'd3;

   // Event codes carried on the result channel
   localparam logic [2:0] EV_HS_OK     = 3'd0;
   localparam logic [2:0] EV_HS_BAD    = 3'd1;
   localparam logic [2:0] EV_KEEPALIVE = 3'd2;
   localparam logic [2:0] EV_PAYLOAD   = 3'd3;
   localparam logic [2:0] EV_EMPTY_MSG = 3'd4;
   localparam logic [2:0] EV_OVERSIZE  = 3'd5;

   // Deframer phase, one-hot
   typedef enum logic [4:0] {
      PH_HANDSHAKE = 5'b00001,
      PH_LENGTH    = 5'b00010,
      PH_TYPE      = 5'b00100,
      PH_PAYLOAD   = 5'b01000,
      PH_DROP      = 5'b10000
   } phase_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]  event_kind;
      logic [7:0]  message_type;
      logic [7:0]  payload_byte;
      logic [16:0] payload_offset;
      logic        last_of_message;
   } result_type;

   // Expected handshake byte at positions 0..19: length prefix, then the
   // protocol string
   function automatic logic [7:0] hs_expected(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = HS_PSTRLEN;
         5'd1:    b = "B";
         5'd2:    b = "i";
         5'd3:    b = "t";
         5'd4:    b = "T";
         5'd5:    b = "o";
         5'd6:    b = "r";
         5'd7:    b = "r";
         5'd8:    b = "e";
         5'd9:    b = "n";
         5'd10:   b = "t";
         5'd11:   b = " ";
         5'd12:   b = "p";
         5'd13:   b = "r";
         5'd14:   b = "o";
         5'd15:   b = "t";
         5'd16:   b = "o";
         5'd17:   b = "c";
         5'd18:   b = "o";
         5'd19:   b = "l";
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[sv/peer_wire_message_deframer_core.sv]
// A byte accepted into the input register is processed when the engine steps, which loads
// its result (if any) into the result register; rsp_valid is high from then on until
// the result is taken. A step waits while the result register holds an untaken result.
// Throughput: one byte per cycle while rsp_ready stays high; a waiting result stalls
// req_ready once the input register holds a byte. Reset is synchronous: clears valids,
// engine to handshake.
module peer_wire_message_deframer_core import pwd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_message_type,
   output logic [7:0]  rsp_payload_byte,
   output logic [16:0] rsp_payload_offset,
   output logic        rsp_last_of_message
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic       advance;
   logic       step;
   logic       emit;
   result_type result;

   // Pipeline control: the engine steps when a byte is buffered and the result slot is free or being taken
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign step        = in_valid_ff && advance;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_valid && req_ready ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = step ? emit : (rsp_valid_ff && !rsp_ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   pwd_frame_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = rsp_data_ff.event_kind;
   assign rsp_message_type    = rsp_data_ff.message_type;
   assign rsp_payload_byte    = rsp_data_ff.payload_byte;
   assign rsp_payload_offset  = rsp_data_ff.payload_offset;
   assign rsp_last_of_message = rsp_data_ff.last_of_message;

   // A buffered byte is never dropped while the result slot is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |=> in_valid_ff)
      else $error("buffered input transaction lost under backpressure");

   // The engine only steps when the result slot can take its output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step |-> (!rsp_valid_ff || rsp_ready))
      else $error("engine stepped with result slot full");

   // Result registers only load on a step that emits
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(step) && $past(emit))
      else $error("result appeared without an emitting step");

endmodule

[sv/pwd_frame_engine.sv]
// Per-byte deframing engine: phase machine, handshake check, length
// assembly and payload counters. One byte is processed per step.
// Depends on pwd_pkg.
module pwd_frame_engine import pwd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       emit,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [6:0]  hs_count_ff, hs_count_in;
   logic        hs_good_ff, hs_good_in;
   logic [23:0] len_shift_ff, len_shift_in;
   logic [1:0]  len_count_ff, len_count_in;
   logic [16:0] remaining_ff, remaining_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [16:0] offset_ff, offset_in;

   logic        hs_match;
   logic [31:0] full_len;
   logic [31:0] len_m1;
   logic        pay_last;

   // Handshake byte check; positions past the protocol string always match
   assign hs_match = (hs_count_ff > HS_CHECK_LAST) ||
                     (rx_byte == hs_expected(hs_count_ff[4:0]));

   assign full_len = {len_shift_ff, rx_byte};
   assign len_m1   = full_len - 32'd1;
   assign pay_last = (remaining_ff <= 17'd1);

   // Next state and result
   always_comb begin
      phase_in     = phase_ff;
      hs_count_in  = hs_count_ff;
      hs_good_in   = hs_good_ff;
      len_shift_in = len_shift_ff;
      len_count_in = len_count_ff;
      remaining_in = remaining_ff;
      cur_type_in  = cur_type_ff;
      offset_in    = offset_ff;
      emit         = 1'b0;
      result       = '0;
      result.last_of_message = 1'b1;

      unique case (phase_ff)
         PH_HANDSHAKE: begin
            hs_good_in = hs_good_ff & hs_match;
            if (hs_count_ff == HS_LAST) begin
               hs_count_in  = '0;
               len_shift_in = '0;
               len_count_in = '0;
               emit         = 1'b1;
               if (hs_good_ff && hs_match) begin
                  phase_in          = PH_LENGTH;
                  result.event_kind = EV_HS_OK;
               end else begin
                  phase_in          = PH_DROP;
                  result.event_kind = EV_HS_BAD;
               end
            end else begin
               hs_count_in = hs_count_ff + 7'd1;
            end
         end
         PH_LENGTH: begin
            len_shift_in = {len_shift_ff[15:0], rx_byte};
            if (len_count_ff != LEN_LAST_BYTE) begin
               len_count_in = len_count_ff + 2'd1;
            end else begin
               len_count_in = '0;
               if (full_len == 32'd0) begin
                  emit              = 1'b1;
                  result.event_kind = EV_KEEPALIVE;
               end else if (full_len > MAX_MESSAGE_LEN) begin
                  emit              = 1'b1;
                  result.event_kind = EV_OVERSIZE;
                  phase_in          = PH_DROP;
               end else begin
                  remaining_in = len_m1[16:0];
                  offset_in    = '0;
                  phase_in     = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            cur_type_in  = rx_byte;
            offset_in    = '0;
            len_shift_in = '0;
            if (remaining_ff == 17'd0) begin
               emit                = 1'b1;
               result.event_kind   = EV_EMPTY_MSG;
               result.message_type = rx_byte;
               phase_in            = PH_LENGTH;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            emit                   = 1'b1;
            result.event_kind      = EV_PAYLOAD;
            result.message_type    = cur_type_ff;
            result.payload_byte    = rx_byte;
            result.payload_offset  = offset_ff;
            result.last_of_message = pay_last;
            if (pay_last) begin
               remaining_in = '0;
               offset_in    = '0;
               phase_in     = PH_LENGTH;
            end else begin
               remaining_in = remaining_ff - 17'd1;
               offset_in    = offset_ff + 17'd1;
            end
         end
         PH_DROP: begin
            phase_in = PH_DROP;
         end
         default: begin
            phase_in = PH_DROP;
         end
      endcase
   end

   // State registers, updated only when a byte is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HANDSHAKE;
         hs_count_ff  <= '0;
         hs_good_ff   <= 1'b1;
         len_shift_ff <= '0;
         len_count_ff <= '0;
         remaining_ff <= '0;
         cur_type_ff  <= '0;
         offset_ff    <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hs_count_ff  <= hs_count_in;
         hs_good_ff   <= hs_good_in;
         len_shift_ff <= len_shift_in;
         len_count_ff <= len_count_in;
         remaining_ff <= remaining_in;
         cur_type_ff  <= cur_type_in;
         offset_ff    <= offset_in;
      end
   end

   // Drop is terminal until reset
   a_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DROP |=> phase_ff == PH_DROP)
      else $error("left drop phase without reset");

   // Handshake verdict only on the final handshake byte
   a_hs_verdict_pos: assert property (@(posedge clock) disable iff (reset)
      step && emit && (result.event_kind == EV_HS_OK || result.event_kind == EV_HS_BAD)
      |-> hs_count_ff == HS_LAST)
      else $error("handshake verdict at wrong byte position");

   // Payload phase always has bytes left to take
   a_payload_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remaining_ff != 17'd0)
      else $error("payload phase with no bytes remaining");

endmodule
